### rtl/tamd_pkg.sv
`default_nettype none

package tamd_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_BITS = 31;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int KEY_BITS  = 8;
    localparam int IDX_BITS  = 8;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic        [COEF_BITS-1:0] coef_t;
    typedef logic        [KEY_BITS-1:0]  key_t;
    typedef logic        [IDX_BITS-1:0]  reg_idx_t;

    typedef struct packed {
        logic  en;
        word_t a;
        coef_t b;
    } mul_req_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam word_t POS_RESET       = word_t'(10) <<< FRAC_BITS;
    localparam coef_t INERTIA_RESET   = coef_t'(6553600);
    localparam coef_t DAMPING_RESET   = coef_t'(655360);
    localparam coef_t INVERSE_RESET   = coef_t'(596);
    localparam coef_t FORCE_RESET     = coef_t'(6554);

    localparam reg_idx_t REG_INERTIA = reg_idx_t'(0);
    localparam reg_idx_t REG_DAMPING = reg_idx_t'(1);
    localparam reg_idx_t REG_INVERSE = reg_idx_t'(2);
    localparam reg_idx_t REG_FORCE   = reg_idx_t'(3);

    localparam key_t KEY_ESC    = key_t'(27);
    localparam key_t KEY_TOGGLE = key_t'(8'h66);
    localparam key_t KEY_UL     = key_t'(8'h65);
    localparam key_t KEY_UP     = key_t'(8'h72);
    localparam key_t KEY_UR     = key_t'(8'h74);
    localparam key_t KEY_RIGHT  = key_t'(8'h67);
    localparam key_t KEY_DR     = key_t'(8'h62);
    localparam key_t KEY_DOWN   = key_t'(8'h76);
    localparam key_t KEY_DL     = key_t'(8'h63);
    localparam key_t KEY_LEFT   = key_t'(8'h64);

    function automatic word_t neg_sat(input word_t x);
        return (x == WORD_MIN) ? WORD_MAX : -x;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
        word_t               bb;
        logic [WORD_BITS:0]  sum;
        bb  = sub ? neg_sat(b) : b;
        sum = {a[WORD_BITS-1], a} + {bb[WORD_BITS-1], bb};
        if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
            return sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return word_t'(sum[WORD_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

### rtl/tamd_mul.sv
`default_nettype none

module tamd_mul (
    input  wire logic              aclk,
    input  wire tamd_pkg::mul_req_t req,
    output tamd_pkg::word_t        q
);
    import tamd_pkg::*;

    logic signed [PROD_BITS-1:0] a_ext;
    logic signed [PROD_BITS-1:0] b_ext;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] shifted;
    logic                        all_ones;
    logic                        all_zeros;

    assign a_ext     = {{(PROD_BITS-WORD_BITS){req.a[WORD_BITS-1]}}, req.a};
    assign b_ext     = {{(PROD_BITS-COEF_BITS){1'b0}}, req.b};
    assign prod_next = a_ext * b_ext;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= prod_next;
        end
    end

    // floor shift, then clamp to the word
    assign shifted   = prod_reg >>> FRAC_BITS;
    assign all_ones  = &shifted[PROD_BITS-1:WORD_BITS-1];
    assign all_zeros = ~|shifted[PROD_BITS-1:WORD_BITS-1];

    always_comb begin
        if (all_ones || all_zeros) begin
            q = word_t'(shifted[WORD_BITS-1:0]);
        end else if (shifted[PROD_BITS-1]) begin
            q = WORD_MIN;
        end else begin
            q = WORD_MAX;
        end
    end

endmodule

`default_nettype wire

### rtl/two_axis_mass_damper_step_core.sv
`default_nettype none

// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        s_tdata key, s_tuser key_present
// m_       out  m_tvalid / m_tready        m_tdata positions, drives, flags
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data (always ready)
//
// A word that integrates is worked on after acceptance: two axes of 7 steps each
// through one shared multiplier and one saturating adder.
// Other words show their result in the cycle after acceptance.
// The next word is accepted in the cycle after the result is taken.
// aresetn is synchronous, active low, and resets all but acc_reg and prod_reg.

module two_axis_mass_damper_step_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // key
    input  wire logic [0:0]                 s_tuser,   // key_present
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [135:0]                    m_tdata,   // new_x, new_y, drive_x, drive_y,
                                                       // is_engaged, still_running
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire tamd_pkg::reg_idx_t         cfg_index,
    input  wire logic [31:0]                cfg_data
);
    import tamd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DBL   = 9'b000000010,
        S_DIFF  = 9'b000000100,
        S_MULA  = 9'b000001000,
        S_MULB  = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_MULC  = 9'b001000000,
        S_STORE = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t   state_reg, state_next;
    logic     axis_reg, axis_next;
    logic     m_valid_reg, m_valid_next;
    logic     alive_reg, alive_next;
    logic     engaged_reg, engaged_next;
    coef_t    inertia_reg, damping_reg, inverse_reg, force_reg;
    word_t    pos_x_reg, prev_x_reg, prev2_x_reg;
    word_t    pos_y_reg, prev_y_reg, prev2_y_reg;
    word_t    push_x_reg, push_x_next, push_y_reg, push_y_next;
    word_t    acc_reg, acc_next;

    logic     accept;
    logic     has_key;
    logic     shift_hist;
    logic     dx_pos, dx_neg, dy_pos, dy_neg;
    word_t    fs;
    word_t    p1, p2, f;
    word_t    add_a, add_b;
    logic     add_sub;
    word_t    add_y;
    word_t    q;
    mul_req_t mreq;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, alive_reg, engaged_reg, push_y_reg, push_x_reg,
                        pos_y_reg, pos_x_reg};
    assign has_key   = s_tuser[0];
    assign fs        = word_t'({1'b0, force_reg});

    assign p1 = axis_reg ? prev_y_reg  : prev_x_reg;
    assign p2 = axis_reg ? prev2_y_reg : prev2_x_reg;
    assign f  = axis_reg ? push_y_reg  : push_x_reg;

    tamd_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .q    (q)
    );

    always_comb begin
        dx_pos = 1'b0;
        dx_neg = 1'b0;
        dy_pos = 1'b0;
        dy_neg = 1'b0;
        unique case (s_tdata)
            KEY_UL:    begin dx_neg = 1'b1; dy_neg = 1'b1; end
            KEY_UP:    begin dy_neg = 1'b1; end
            KEY_UR:    begin dx_pos = 1'b1; dy_neg = 1'b1; end
            KEY_RIGHT: begin dx_pos = 1'b1; end
            KEY_DR:    begin dx_pos = 1'b1; dy_pos = 1'b1; end
            KEY_DOWN:  begin dy_pos = 1'b1; end
            KEY_DL:    begin dx_neg = 1'b1; dy_pos = 1'b1; end
            KEY_LEFT:  begin dx_neg = 1'b1; end
            default:   ;
        endcase
        if (!has_key) begin
            dx_pos = 1'b0;
            dx_neg = 1'b0;
            dy_pos = 1'b0;
            dy_neg = 1'b0;
        end
    end

    always_comb begin
        add_a   = p1;
        add_b   = p1;
        add_sub = 1'b0;
        mreq.en = 1'b0;
        mreq.a  = acc_reg;
        mreq.b  = inertia_reg;
        unique case (state_reg)
            S_DIFF: begin
                add_a   = p2;
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            S_MULA: begin
                mreq.en = 1'b1;
            end
            S_MULB: begin
                add_a   = f;
                add_b   = q;
                add_sub = 1'b1;
                mreq.en = 1'b1;
                mreq.a  = p1;
                mreq.b  = damping_reg;
            end
            S_SUM: begin
                add_a = acc_reg;
                add_b = q;
            end
            S_MULC: begin
                mreq.en = 1'b1;
                mreq.b  = inverse_reg;
            end
            default: ;
        endcase
    end

    assign add_y = sat_add(add_a, add_b, add_sub);

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg;
        alive_next   = alive_reg;
        engaged_next = engaged_reg;
        push_x_next  = push_x_reg;
        push_y_next  = push_y_reg;
        acc_next     = acc_reg;
        shift_hist   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_OUT;
                    m_valid_next = 1'b1;
                    axis_next    = 1'b0;
                    if (alive_reg) begin
                        if (has_key && s_tdata == KEY_ESC) begin
                            alive_next = 1'b0;
                        end
                        if (has_key && s_tdata == KEY_TOGGLE) begin
                            engaged_next = !engaged_reg;
                        end else if (engaged_reg) begin
                            if (dx_pos) push_x_next = sat_add(push_x_reg, fs, 1'b0);
                            if (dx_neg) push_x_next = sat_add(push_x_reg, fs, 1'b1);
                            if (dy_pos) push_y_next = sat_add(push_y_reg, fs, 1'b0);
                            if (dy_neg) push_y_next = sat_add(push_y_reg, fs, 1'b1);
                            shift_hist   = 1'b1;
                            state_next   = S_DBL;
                            m_valid_next = 1'b0;
                        end
                    end
                end
            end
            S_DBL: begin
                acc_next   = add_y;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                acc_next   = add_y;
                state_next = S_MULA;
            end
            S_MULA: begin
                state_next = S_MULB;
            end
            S_MULB: begin
                acc_next   = add_y;
                state_next = S_SUM;
            end
            S_SUM: begin
                acc_next   = add_y;
                state_next = S_MULC;
            end
            S_MULC: begin
                state_next = S_STORE;
            end
            S_STORE: begin
                if (axis_reg) begin
                    state_next   = S_OUT;
                    m_valid_next = 1'b1;
                end else begin
                    axis_next  = 1'b1;
                    state_next = S_DBL;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            alive_reg   <= 1'b1;
            engaged_reg <= 1'b0;
            push_x_reg  <= '0;
            push_y_reg  <= '0;
            pos_x_reg   <= POS_RESET;
            prev_x_reg  <= POS_RESET;
            prev2_x_reg <= POS_RESET;
            pos_y_reg   <= POS_RESET;
            prev_y_reg  <= POS_RESET;
            prev2_y_reg <= POS_RESET;
            inertia_reg <= INERTIA_RESET;
            damping_reg <= DAMPING_RESET;
            inverse_reg <= INVERSE_RESET;
            force_reg   <= FORCE_RESET;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
            alive_reg   <= alive_next;
            engaged_reg <= engaged_next;
            push_x_reg  <= push_x_next;
            push_y_reg  <= push_y_next;
            if (shift_hist) begin
                prev2_x_reg <= prev_x_reg;
                prev2_y_reg <= prev_y_reg;
                prev_x_reg  <= pos_x_reg;
                prev_y_reg  <= pos_y_reg;
            end
            if (state_reg == S_STORE) begin
                if (axis_reg) begin
                    pos_y_reg <= q;
                end else begin
                    pos_x_reg <= q;
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_INERTIA: inertia_reg <= cfg_data[COEF_BITS-1:0];
                    REG_DAMPING: damping_reg <= cfg_data[COEF_BITS-1:0];
                    REG_INVERSE: inverse_reg <= cfg_data[COEF_BITS-1:0];
                    REG_FORCE:   force_reg   <= cfg_data[COEF_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready did not drop after an accepted word");

    a_escape_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !alive_reg |=> !alive_reg)
        else $error("running flag came back after escape");

    a_pos_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("position moved outside the integration sequence");

    a_frozen_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !engaged_reg) |=> (state_reg == S_OUT))
        else $error("frozen word entered the integration sequence");
`endif

endmodule

`default_nettype wire

### tb/sv/tamd_step_checker.sv
`timescale 1ns / 100ps

module tamd_step_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [7:0]          s_tdata,   // key
    input  wire logic [0:0]          s_tuser,   // key_present
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [135:0]        m_tdata,   // new_x, new_y, drive_x, drive_y,
                                                // is_engaged, still_running
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire tamd_pkg::reg_idx_t  cfg_index,
    input  wire logic [31:0]         cfg_data,
    output int                       error_count,
    output int                       open_ticks
);
    import tamd_pkg::*;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t drive_x;
        word_t drive_y;
        logic  engaged;
        logic  running;
    } tick_result_t;

    coef_t inertia;
    coef_t damping;
    coef_t inv_total;
    coef_t force_inc;

    word_t x_now, x_last, x_older;
    word_t y_now, y_last, y_older;
    word_t force_x, force_y;
    logic  engaged_q;
    logic  running_q;

    tick_result_t expected_ticks [$];
    int           errors    = 0;
    int           result_no = 0;
    int           pending   = 0;

    assign error_count = errors;
    assign open_ticks  = pending;

    function automatic word_t clip_long(input longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return word_t'(v);
    endfunction

    function automatic word_t clip_add(input word_t a, input word_t b);
        return clip_long(longint'(a) + longint'(b));
    endfunction

    function automatic word_t clip_neg(input word_t a);
        return clip_long(-longint'(a));
    endfunction

    // exact product, floor shift, saturate
    function automatic word_t fixed_mul(input word_t s, input coef_t c);
        longint prod;
        prod = longint'(s) * longint'({1'b0, c});
        return clip_long(prod >>> FRAC_BITS);
    endfunction

    function automatic word_t integrate_axis(input word_t p1, input word_t p2, input word_t f);
        word_t d, ta, tb, s;
        d  = clip_add(p2, clip_neg(clip_add(p1, p1)));
        ta = fixed_mul(d, inertia);
        tb = fixed_mul(p1, damping);
        s  = clip_add(clip_add(f, clip_neg(ta)), tb);
        return fixed_mul(s, inv_total);
    endfunction

    task automatic apply_tick(input logic present, input key_t key);
        int           dx, dy;
        word_t        step;
        tick_result_t r;
        dx   = 0;
        dy   = 0;
        step = word_t'({1'b0, force_inc});
        if (running_q) begin
            if (present && key == KEY_ESC) running_q = 1'b0;
            if (present && key == KEY_TOGGLE) begin
                engaged_q = !engaged_q;
            end else if (engaged_q) begin
                if (present) begin
                    case (key)
                        KEY_UL:    begin dx = -1; dy = -1; end
                        KEY_UP:    begin dy = -1; end
                        KEY_UR:    begin dx = 1; dy = -1; end
                        KEY_RIGHT: begin dx = 1; end
                        KEY_DR:    begin dx = 1; dy = 1; end
                        KEY_DOWN:  begin dy = 1; end
                        KEY_DL:    begin dx = -1; dy = 1; end
                        KEY_LEFT:  begin dx = -1; end
                        default:   ;
                    endcase
                end
                if (dx > 0) force_x = clip_add(force_x, step);
                if (dx < 0) force_x = clip_add(force_x, -step);
                if (dy > 0) force_y = clip_add(force_y, step);
                if (dy < 0) force_y = clip_add(force_y, -step);
                x_older = x_last;
                y_older = y_last;
                x_last  = x_now;
                y_last  = y_now;
                x_now   = integrate_axis(x_last, x_older, force_x);
                y_now   = integrate_axis(y_last, y_older, force_y);
            end
        end
        r.x       = x_now;
        r.y       = y_now;
        r.drive_x = force_x;
        r.drive_y = force_y;
        r.engaged = engaged_q;
        r.running = running_q;
        expected_ticks.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("word %0d %s: got %h, want %h",
                                      result_no, name, got, want));
        end
    endtask

    task automatic check_result(input logic [135:0] word);
        tick_result_t want;
        if (expected_ticks.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with no tick pending", result_no));
        end else begin
            want = expected_ticks.pop_front();
            compare_field("new_x",         word[31:0],            want.x);
            compare_field("new_y",         word[63:32],           want.y);
            compare_field("drive_x",       word[95:64],           want.drive_x);
            compare_field("drive_y",       word[127:96],          want.drive_y);
            compare_field("is_engaged",    {31'b0, word[128]},    {31'b0, want.engaged});
            compare_field("still_running", {31'b0, word[129]},    {31'b0, want.running});
        end
        result_no++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            inertia   = INERTIA_RESET;
            damping   = DAMPING_RESET;
            inv_total = INVERSE_RESET;
            force_inc = FORCE_RESET;
            x_now     = POS_RESET;
            x_last    = POS_RESET;
            x_older   = POS_RESET;
            y_now     = POS_RESET;
            y_last    = POS_RESET;
            y_older   = POS_RESET;
            force_x   = '0;
            force_y   = '0;
            engaged_q = 1'b0;
            running_q = 1'b1;
            expected_ticks.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_INERTIA: inertia   = cfg_data[COEF_BITS-1:0];
                    REG_DAMPING: damping   = cfg_data[COEF_BITS-1:0];
                    REG_INVERSE: inv_total = cfg_data[COEF_BITS-1:0];
                    REG_FORCE:   force_inc = cfg_data[COEF_BITS-1:0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready) apply_tick(s_tuser[0], s_tdata);
        end
        pending = expected_ticks.size();
    end

endmodule

### tb/sv/two_axis_mass_damper_step_core_tb.sv
`timescale 1ns / 100ps

module two_axis_mass_damper_step_core_tb;
    import tamd_pkg::*;

    localparam int       RUN_LIMIT      = 400000;
    localparam reg_idx_t REG_SPARE_LOW  = reg_idx_t'(4);
    localparam reg_idx_t REG_SPARE_TOP  = reg_idx_t'(8'hFF);
    localparam key_t     KEY_NONE_LOW   = key_t'(8'h00);
    localparam key_t     KEY_NONE_TOP   = key_t'(8'hFF);
    localparam key_t     KEY_PLAIN      = key_t'(8'h7A);
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] COEF_TOP    = 32'h7FFF_FFFF;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_tvalid  = 1'b0;
    wire            s_tready;
    logic [7:0]     s_tdata   = '0;
    logic [0:0]     s_tuser   = '0;
    wire            m_tvalid;
    logic           m_tready  = 1'b0;
    wire  [135:0]   m_tdata;
    logic           cfg_valid = 1'b0;
    wire            cfg_ready;
    reg_idx_t       cfg_index = '0;
    logic [31:0]    cfg_data  = '0;

    int   error_count;
    int   open_ticks;
    bit   quiet        = 1'b0;
    int   cycles       = 0;
    int   stall_left   = 0;
    logic last_engaged = 1'b0;

    two_axis_mass_damper_step_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tamd_step_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .open_ticks  (open_ticks)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) last_engaged <= m_tdata[128];
    end

    // result side: stall in random bursts
    always @(negedge aclk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic key_t dir_key(input int n);
        case (n)
            0:       return KEY_UL;
            1:       return KEY_UP;
            2:       return KEY_UR;
            3:       return KEY_RIGHT;
            4:       return KEY_DR;
            5:       return KEY_DOWN;
            6:       return KEY_DL;
            default: return KEY_LEFT;
        endcase
    endfunction

    task automatic send_tick(input logic present, input key_t key);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= present;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (open_ticks != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // mostly direction keys; no escape here
    task automatic send_random_tick;
        int    pick;
        logic  present;
        key_t  key;
        pick    = $urandom_range(0, 99);
        present = 1'b1;
        key     = key_t'($urandom_range(0, 255));
        if (pick < 60) key = dir_key($urandom_range(0, 7));
        else if (pick < 65) key = KEY_TOGGLE;
        else if (pick < 80) present = 1'b0;
        else if (key == KEY_ESC) present = 1'b0;
        send_tick(present, key);
    endtask

    task automatic run_phase(input logic [31:0] inertia, input logic [31:0] damping,
                             input logic [31:0] inverse, input logic [31:0] force_inc,
                             input int count);
        drain;
        write_reg(REG_INERTIA, inertia);
        write_reg(REG_DAMPING, damping);
        write_reg(REG_INVERSE, inverse);
        write_reg(REG_FORCE, force_inc);
        repeat (count) begin
            if ($urandom_range(0, 199) == 0) drain;
            send_random_tick;
        end
    endtask

    initial begin
        int     i;
        longint a_val, b_val, c_val, f_val;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_tick(1'b0, KEY_UL);
        send_tick(1'b1, KEY_RIGHT);
        send_tick(1'b1, KEY_TOGGLE);
        for (i = 0; i < 8; i++) send_tick(1'b1, dir_key(i));
        send_tick(1'b0, KEY_TOGGLE);
        send_tick(1'b0, KEY_ESC);
        send_tick(1'b1, KEY_NONE_LOW);
        send_tick(1'b1, KEY_NONE_TOP);
        send_tick(1'b1, KEY_PLAIN);
        send_tick(1'b1, KEY_TOGGLE);
        send_tick(1'b1, KEY_LEFT);
        send_tick(1'b0, KEY_NONE_TOP);
        send_tick(1'b1, KEY_TOGGLE);

        repeat (150) send_random_tick;

        run_phase(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 100);
        run_phase('0, '0, '0, '0, 100);

        drain;
        write_reg(REG_SPARE_LOW, $urandom);
        write_reg(REG_SPARE_TOP, $urandom);

        repeat (3) begin
            a_val = $urandom_range(1, 1 << 24);
            b_val = $urandom_range(0, 1 << 22);
            c_val = (64'd1 << 32) / (a_val + b_val);
            if (c_val > longint'(COEF_TOP)) c_val = longint'(COEF_TOP);
            f_val = $urandom_range(0, 1 << 20);
            run_phase(a_val[31:0], b_val[31:0], c_val[31:0], f_val[31:0], 150);
        end

        run_phase('0, COEF_TOP, 32'd1, 32'd1, 100);

        quiet = 1'b1;
        run_phase({1'b0, INERTIA_RESET}, {1'b0, DAMPING_RESET}, {1'b0, INVERSE_RESET},
                  {1'b0, FORCE_RESET}, 120);

        // escape while engaged, then ticks that must change nothing
        drain;
        if (!last_engaged) send_tick(1'b1, KEY_TOGGLE);
        send_tick(1'b1, KEY_ESC);
        send_tick(1'b1, KEY_TOGGLE);
        send_tick(1'b1, KEY_ESC);
        send_tick(1'b1, KEY_UP);
        repeat (27) send_random_tick;

        drain;
        repeat (20) @(negedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### two_axis_mass_damper_step_core.f
rtl/tamd_pkg.sv
rtl/tamd_mul.sv
rtl/two_axis_mass_damper_step_core.sv
tb/sv/tamd_step_checker.sv
tb/sv/two_axis_mass_damper_step_core_tb.sv
